### sv/gbc_pkg.sv
// Package for the gyro bias calibrate-and-correct block.
// Holds the control state type, the lane control struct and shared codes.
// No dependencies.
package gbc_pkg;

   localparam logic       KIND_START        = 1'b0;
   localparam logic       KIND_SAMPLE       = 1'b1;
   localparam logic       RSP_SAMPLE        = 1'b0;
   localparam logic       RSP_REPORT        = 1'b1;
   localparam logic [15:0] CAL_SAMPLES_RESET = 16'd200;
   localparam logic [15:0] COUNT_MAX         = 16'hFFFF;
   localparam int         DIV_STEPS         = 32;
   localparam int         STEP_W            = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIVIDE,
      ST_REPORT
   } ctrl_state_type;

   // Control shared by all three axis lanes
   typedef struct packed {
      logic clear;          // clear the running sum
      logic accumulate;     // add the sample into the sum
      logic load_dividend;  // start a division from the sum
      logic div_step;       // one restoring division step
      logic load_bias;      // take the quotient as the new bias
      logic bias_valid;     // subtract the bias from samples
   } lane_ctrl_type;

endpackage

### sv/gbc_lane.sv
// One axis lane: running sum, bit-serial signed divider and bias correction.
// Depends on gbc_pkg.
module gbc_lane import gbc_pkg::*; (
   input  logic                clock,
   input  lane_ctrl_type       ctrl,
   input  logic signed [15:0]  rate,
   input  logic        [15:0]  divisor,
   output logic signed [15:0]  corr,
   output logic signed [15:0]  quot
);

   logic [31:0] sum_ff, sum_in;
   logic [15:0] bias_ff;
   logic [31:0] dvd_ff;
   logic [15:0] rem_ff;
   logic        neg_ff;

   logic [16:0] rem_shift;
   logic [16:0] rem_sub;
   logic        rem_ge;
   logic [15:0] quot_mag;

   always_comb begin
      sum_in = sum_ff;
      if (ctrl.clear) begin
         sum_in = 32'd0;
      end else if (ctrl.accumulate) begin
         sum_in = sum_ff + {{16{rate[15]}}, rate};
      end
   end

   // Restoring step: bring in the next dividend bit, subtract when it fits
   assign rem_shift = {rem_ff, dvd_ff[31]};
   assign rem_sub   = rem_shift - {1'b0, divisor};
   assign rem_ge    = rem_shift >= {1'b0, divisor};

   // Truncation toward zero: divide magnitudes, then restore the sign
   assign quot_mag = dvd_ff[15:0];
   assign quot     = neg_ff ? 16'(16'd0 - quot_mag) : quot_mag;

   assign corr = ctrl.bias_valid ? 16'(rate - bias_ff) : rate;

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (ctrl.load_dividend) begin
         dvd_ff <= sum_ff[31] ? 32'(32'd0 - sum_ff) : sum_ff;
         rem_ff <= 16'd0;
         neg_ff <= sum_ff[31];
      end else if (ctrl.div_step) begin
         dvd_ff <= {dvd_ff[30:0], rem_ge};
         rem_ff <= rem_ge ? rem_sub[15:0] : rem_shift[15:0];
      end
      if (ctrl.load_bias) begin
         bias_ff <= quot;
      end
   end

endmodule

### sv/gbc_merge.sv
// Result register that merges the three lane values into one transaction.
// Depends on gbc_pkg.
module gbc_merge import gbc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic               kind,
   input  logic signed [15:0] val_x,
   input  logic signed [15:0] val_y,
   input  logic signed [15:0] val_z,
   input  logic               ok,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z,
   output logic               rsp_cal_ok
);

   logic        valid_ff, valid_in;
   logic        kind_ff;
   logic [15:0] x_ff, y_ff, z_ff;
   logic        ok_ff;

   // Free when empty or draining this cycle
   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind;
         x_ff    <= val_x;
         y_ff    <= val_y;
         z_ff    <= val_z;
         ok_ff   <= ok;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_out_x       = x_ff;
   assign rsp_out_y       = y_ff;
   assign rsp_out_z       = z_ff;
   assign rsp_cal_ok      = ok_ff;

endmodule

### sv/gyro_bias_calibrate_and_correct.sv
// Gyro bias calibrate-and-correct: run control, three axis lanes, result register.
// A corrected sample or a failed-run report appears in the cycle after accept; a
// successful run's report follows a load step, 32 steps of the per-lane bit-serial
// divider and a report step held for a free result register, input stalled meanwhile.
// Else one transaction per cycle while that register is free. Synchronous active-high
// reset clears the run state and bias-valid flag and sets calibration_samples to 200.
module gyro_bias_calibrate_and_correct import gbc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic               req_read_ok,
   input  logic signed [15:0] req_rate_x,
   input  logic signed [15:0] req_rate_y,
   input  logic signed [15:0] req_rate_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z,
   output logic               rsp_cal_ok,
   input  logic               csr_wr_en,
   input  logic        [15:0] csr_wr_data
);

   ctrl_state_type state_ff, state_in;
   logic [15:0]       cal_ff;
   logic              calibrating_ff, calibrating_in;
   logic              bias_valid_ff, bias_valid_in;
   logic [15:0]       seen_ff, seen_in;
   logic [15:0]       good_ff, good_in;
   logic [STEP_W-1:0] step_ff, step_in;

   lane_ctrl_type     lane_ctrl;
   logic              accept;
   logic              out_free;
   logic              out_load;
   logic              out_kind;
   logic              out_ok;
   logic              sel_quot;
   logic              sel_zero;
   logic signed [15:0] corr_x, corr_y, corr_z;
   logic signed [15:0] quot_x, quot_y, quot_z;
   logic signed [15:0] val_x, val_y, val_z;
   logic [15:0]       seen_inc, good_inc;

   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   assign seen_inc = (seen_ff < COUNT_MAX) ? 16'(seen_ff + 16'd1) : seen_ff;
   assign good_inc = (good_ff < COUNT_MAX) ? 16'(good_ff + 16'd1) : good_ff;

   always_comb begin
      state_in       = state_ff;
      calibrating_in = calibrating_ff;
      bias_valid_in  = bias_valid_ff;
      seen_in        = seen_ff;
      good_in        = good_ff;
      step_in        = step_ff;
      lane_ctrl      = '0;
      out_load       = 1'b0;
      out_kind       = RSP_SAMPLE;
      out_ok         = bias_valid_ff;
      sel_quot       = 1'b0;
      sel_zero       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == KIND_START) begin
               lane_ctrl.clear = 1'b1;
               bias_valid_in   = 1'b0;
               calibrating_in  = 1'b1;
               seen_in         = 16'd0;
               good_in         = 16'd0;
               // Empty run: fail at once
               if (cal_ff == 16'd0) begin
                  calibrating_in = 1'b0;
                  out_load       = 1'b1;
                  out_kind       = RSP_REPORT;
                  out_ok         = 1'b0;
                  sel_zero       = 1'b1;
               end
            end else if (accept && calibrating_ff) begin
               if (req_read_ok) begin
                  lane_ctrl.accumulate = 1'b1;
                  good_in              = good_inc;
               end
               seen_in = seen_inc;
               if (seen_in >= cal_ff) begin
                  calibrating_in = 1'b0;
                  if (good_in == 16'd0 || good_in < (cal_ff >> 1)) begin
                     bias_valid_in = 1'b0;
                     out_load      = 1'b1;
                     out_kind      = RSP_REPORT;
                     out_ok        = 1'b0;
                     sel_zero      = 1'b1;
                  end else begin
                     state_in = ST_LOAD;
                  end
               end
            end else if (accept && req_read_ok) begin
               lane_ctrl.bias_valid = bias_valid_ff;
               out_load             = 1'b1;
            end
         end
         ST_LOAD: begin
            lane_ctrl.load_dividend = 1'b1;
            step_in                 = '0;
            state_in                = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            lane_ctrl.div_step = 1'b1;
            step_in            = STEP_W'(step_ff + 1'b1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            // Hold until the result register can take the report
            if (out_free) begin
               lane_ctrl.load_bias = 1'b1;
               bias_valid_in       = 1'b1;
               out_load            = 1'b1;
               out_kind            = RSP_REPORT;
               out_ok              = 1'b1;
               sel_quot            = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cal_ff         <= CAL_SAMPLES_RESET;
         calibrating_ff <= 1'b0;
         bias_valid_ff  <= 1'b0;
         seen_ff        <= 16'd0;
         good_ff        <= 16'd0;
         step_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         calibrating_ff <= calibrating_in;
         bias_valid_ff  <= bias_valid_in;
         seen_ff        <= seen_in;
         good_ff        <= good_in;
         step_ff        <= step_in;
         if (csr_wr_en) begin
            cal_ff <= csr_wr_data;
         end
      end
   end

   gbc_lane u_lane_x (
      .clock   (clock),
      .ctrl    (lane_ctrl),
      .rate    (req_rate_x),
      .divisor (good_ff),
      .corr    (corr_x),
      .quot    (quot_x)
   );

   gbc_lane u_lane_y (
      .clock   (clock),
      .ctrl    (lane_ctrl),
      .rate    (req_rate_y),
      .divisor (good_ff),
      .corr    (corr_y),
      .quot    (quot_y)
   );

   gbc_lane u_lane_z (
      .clock   (clock),
      .ctrl    (lane_ctrl),
      .rate    (req_rate_z),
      .divisor (good_ff),
      .corr    (corr_z),
      .quot    (quot_z)
   );

   always_comb begin
      if (sel_zero) begin
         val_x = 16'sd0;
         val_y = 16'sd0;
         val_z = 16'sd0;
      end else if (sel_quot) begin
         val_x = quot_x;
         val_y = quot_y;
         val_z = quot_z;
      end else begin
         val_x = corr_x;
         val_y = corr_y;
         val_z = corr_z;
      end
   end

   gbc_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .load            (out_load),
      .kind            (out_kind),
      .val_x           (val_x),
      .val_y           (val_y),
      .val_z           (val_z),
      .ok              (out_ok),
      .free            (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_cal_ok      (rsp_cal_ok)
   );

endmodule

### test/tb_gyro_bias_calibrate_and_correct.sv
`timescale 1ns / 100ps
// Testbench for gyro_bias_calibrate_and_correct: directed table, then random calibration
// runs, noise and corrected-sample streams, all scored against a bias predictor.
// Depends on gbc_pkg and the block's RTL.
module tb_gyro_bias_calibrate_and_correct;
   import gbc_pkg::*;

   localparam int RANDOM_ITEMS  = 1450;
   localparam int SETTLE_CYCLES = 40;
   localparam int LIMIT_CYCLES  = 600000;

   typedef struct packed {
      logic        kind;
      logic        read_ok;
      logic [15:0] rate_x;
      logic [15:0] rate_y;
      logic [15:0] rate_z;
   } gyro_req_type;

   typedef struct packed {
      logic        result_kind;
      logic [15:0] out_x;
      logic [15:0] out_y;
      logic [15:0] out_z;
      logic        cal_ok;
   } gyro_rsp_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_op_type;

   typedef struct {
      row_op_type   op;
      logic [15:0]  csr_value;
      gyro_req_type item;
      bit           typed;
      gyro_rsp_type want;
   } dir_row_type;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY
   } stall_mode_type;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic               req_kind    = KIND_SAMPLE;
   logic               req_read_ok = 1'b0;
   logic signed [15:0] req_rate_x  = '0;
   logic signed [15:0] req_rate_y  = '0;
   logic signed [15:0] req_rate_z  = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic               rsp_result_kind;
   logic signed [15:0] rsp_out_x;
   logic signed [15:0] rsp_out_y;
   logic signed [15:0] rsp_out_z;
   logic               rsp_cal_ok;
   logic               csr_wr_en   = 1'b0;
   logic        [15:0] csr_wr_data = '0;

   // Typed expectation that travels with the transaction on the request bus
   bit                 row_typed   = 1'b0;
   gyro_rsp_type       row_want    = '0;

   // Predictor state
   logic        [15:0] cal_len_q   = CAL_SAMPLES_RESET;
   logic               cal_active  = 1'b0;
   logic        [15:0] seen_cnt    = '0;
   logic        [15:0] good_cnt    = '0;
   logic signed [31:0] axis_sum [3];
   logic        [15:0] axis_bias [3];
   logic               bias_ok     = 1'b0;

   gyro_rsp_type       pending_gyro_out [$];
   dir_row_type        dir_rows [$];
   int                 errors      = 0;
   int                 cycle_cnt   = 0;
   int                 burst_left  = 0;
   logic        [15:0] drv_len     = CAL_SAMPLES_RESET;
   stall_mode_type     stall_mode  = STALL_NONE;
   int                 stall_tick  = 0;

   gyro_bias_calibrate_and_correct dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_read_ok     (req_read_ok),
      .req_rate_x      (req_rate_x),
      .req_rate_y      (req_rate_y),
      .req_rate_z      (req_rate_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_cal_ok      (rsp_cal_ok),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == LIMIT_CYCLES) begin
         $display("gyro_bias_calibrate_and_correct test failed");
         $finish;
      end
   end

   // Receiver back-pressure in one of four randomly switched stall patterns
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 300 == 0) stall_mode <= stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 2) == 0);
         STALL_PERIODIC: rsp_stall <= ((stall_tick % 7) < 3);
         default:        rsp_stall <= ($urandom_range(0, 4) != 0);
      endcase
   end

   task automatic check_field(input string name, input int e, input int a);
      if (e != a) begin
         errors++;
         $error("%s: expected %0d, got %0d", name, e, a);
      end
   endtask

   // End a calibration run and build its report
   task automatic close_calibration(output gyro_rsp_type r);
      longint quo;
      cal_active = 1'b0;
      r = '0;
      r.result_kind = RSP_REPORT;
      if (good_cnt == 0 || good_cnt < (cal_len_q >> 1)) begin
         bias_ok = 1'b0;
      end else begin
         for (int i = 0; i < 3; i++) begin
            quo = longint'(axis_sum[i]) / longint'(good_cnt);
            axis_bias[i] = quo[15:0];
         end
         bias_ok = 1'b1;
         r.out_x = axis_bias[0];
         r.out_y = axis_bias[1];
         r.out_z = axis_bias[2];
      end
      r.cal_ok = bias_ok;
   endtask

   task automatic predict_gyro_out(input gyro_req_type it, output bit has,
                                   output gyro_rsp_type r);
      logic [15:0] rate [3];
      rate[0] = it.rate_x;
      rate[1] = it.rate_y;
      rate[2] = it.rate_z;
      has = 1'b0;
      r = '0;
      if (it.kind == KIND_START) begin
         bias_ok    = 1'b0;
         cal_active = 1'b1;
         seen_cnt   = '0;
         good_cnt   = '0;
         for (int i = 0; i < 3; i++) axis_sum[i] = '0;
         if (cal_len_q == 0) begin
            close_calibration(r);
            has = 1'b1;
         end
      end else if (cal_active) begin
         if (it.read_ok) begin
            for (int i = 0; i < 3; i++) axis_sum[i] = axis_sum[i] + $signed(rate[i]);
            if (good_cnt != COUNT_MAX) good_cnt = good_cnt + 1'b1;
         end
         if (seen_cnt != COUNT_MAX) seen_cnt = seen_cnt + 1'b1;
         if (seen_cnt >= cal_len_q) begin
            close_calibration(r);
            has = 1'b1;
         end
      end else if (it.read_ok) begin
         has = 1'b1;
         r.result_kind = RSP_SAMPLE;
         r.out_x  = bias_ok ? rate[0] - axis_bias[0] : rate[0];
         r.out_y  = bias_ok ? rate[1] - axis_bias[1] : rate[1];
         r.out_z  = bias_ok ? rate[2] - axis_bias[2] : rate[2];
         r.cal_ok = bias_ok;
      end
   endtask

   always @(posedge clock) begin : gyro_watch
      gyro_rsp_type want;
      gyro_rsp_type got;
      bit           has;
      if (reset) begin
         cal_len_q  = CAL_SAMPLES_RESET;
         cal_active = 1'b0;
         seen_cnt   = '0;
         good_cnt   = '0;
         bias_ok    = 1'b0;
         for (int i = 0; i < 3; i++) begin
            axis_sum[i]  = '0;
            axis_bias[i] = '0;
         end
      end else begin
         // Check before pushing: a result never belongs to a transaction of the same edge
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_result_kind, rsp_out_x, rsp_out_y, rsp_out_z, rsp_cal_ok};
            if (pending_gyro_out.size() == 0) begin
               errors++;
               $error("unexpected result: result_kind %0d out %0d %0d %0d cal_ok %0d",
                      got.result_kind, $signed(got.out_x), $signed(got.out_y),
                      $signed(got.out_z), got.cal_ok);
            end else begin
               want = pending_gyro_out.pop_front();
               check_field("result_kind", want.result_kind, got.result_kind);
               check_field("out_x", $signed(want.out_x), $signed(got.out_x));
               check_field("out_y", $signed(want.out_y), $signed(got.out_y));
               check_field("out_z", $signed(want.out_z), $signed(got.out_z));
               check_field("cal_ok", want.cal_ok, got.cal_ok);
            end
         end
         if (csr_wr_en) cal_len_q = csr_wr_data;
         if (req_valid && !req_stall) begin
            predict_gyro_out({req_kind, req_read_ok, req_rate_x, req_rate_y, req_rate_z},
                             has, want);
            if (has) pending_gyro_out.push_back(row_typed ? row_want : want);
         end
      end
   end

   task automatic send_item(input gyro_req_type it, input bit typed,
                            input gyro_rsp_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_kind    <= it.kind;
      req_read_ok <= it.read_ok;
      req_rate_x  <= it.rate_x;
      req_rate_y  <= it.rate_y;
      req_rate_z  <= it.rate_z;
      row_typed   <= typed;
      row_want    <= want;
      do @(posedge clock); while (req_stall);
      burst_left--;
   endtask

   // Hold off until every expected result is in, then let the block settle
   task automatic drain_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_gyro_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_cal_len(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      drv_len = value;
   endtask

   function automatic void add_checked(input logic kind, input logic ok, input int x,
                                       input int y, input int z, input logic rkind,
                                       input int ox, input int oy, input int oz,
                                       input logic cok);
      dir_row_type row;
      row.op        = ROW_ITEM;
      row.csr_value = '0;
      row.item      = {kind, ok, 16'(x), 16'(y), 16'(z)};
      row.typed     = 1'b1;
      row.want      = {rkind, 16'(ox), 16'(oy), 16'(oz), cok};
      dir_rows.push_back(row);
   endfunction

   function automatic void add_item(input logic kind, input logic ok, input int x,
                                    input int y, input int z);
      dir_row_type row;
      row.op        = ROW_ITEM;
      row.csr_value = '0;
      row.item      = {kind, ok, 16'(x), 16'(y), 16'(z)};
      row.typed     = 1'b0;
      row.want      = '0;
      dir_rows.push_back(row);
   endfunction

   function automatic void add_csr(input int value);
      dir_row_type row;
      row.op        = ROW_CSR;
      row.csr_value = 16'(value);
      row.item      = '0;
      row.typed     = 1'b0;
      row.want      = '0;
      dir_rows.push_back(row);
   endfunction

   function automatic logic [15:0] jitter_rate(input logic [15:0] center);
      case ($urandom_range(0, 15))
         0: begin
            case ($urandom_range(0, 3))
               0:       return 16'h7FFF;
               1:       return 16'h8000;
               2:       return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         1, 2, 3: return 16'($urandom);
         default: return center + 16'($urandom_range(0, 64)) - 16'd32;
      endcase
   endfunction

   function automatic gyro_req_type make_sample(input logic ok, input logic [15:0] cx,
                                                input logic [15:0] cy,
                                                input logic [15:0] cz);
      return {KIND_SAMPLE, ok, jitter_rate(cx), jitter_rate(cy), jitter_rate(cz)};
   endfunction

   function automatic gyro_req_type make_start();
      return {KIND_START, 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
              16'($urandom)};
   endfunction

   function automatic logic [15:0] pick_center();
      if ($urandom_range(0, 1)) return 16'($urandom);
      return 16'($urandom_range(0, 400)) - 16'd200;
   endfunction

   initial begin
      int          counted;
      int          n;
      int          m;
      int          ok_pct;
      int          pick;
      bit          restarted;
      logic        ok;
      logic        kind;
      logic [15:0] cx;
      logic [15:0] cy;
      logic [15:0] cz;

      // Pass-through with no bias, then a run at the reset length cut short
      add_checked(KIND_SAMPLE, 1, 32767, -32768, 0, RSP_SAMPLE, 32767, -32768, 0, 0);
      add_checked(KIND_SAMPLE, 1, -1, 1, -32768, RSP_SAMPLE, -1, 1, -32768, 0);
      add_item(KIND_START, 1, 16'h1234, 16'h5678, 16'h9ABC);
      add_item(KIND_SAMPLE, 1, 10, 20, 30);
      add_item(KIND_SAMPLE, 0, 1, 2, 3);
      // Zero run length: the start itself reports failure
      add_csr(0);
      add_checked(KIND_START, 0, 0, 0, 0, RSP_REPORT, 0, 0, 0, 0);
      // Four-sample run with a bad read, full-scale sums
      add_csr(4);
      add_item(KIND_START, 0, 0, 0, 0);
      add_item(KIND_SAMPLE, 1, 32767, 32767, -32768);
      add_item(KIND_SAMPLE, 0, -1, -1, -1);
      add_item(KIND_SAMPLE, 1, 32767, 32767, -32768);
      add_item(KIND_SAMPLE, 1, 32767, -32768, -32768);
      add_item(KIND_SAMPLE, 1, -32768, 32767, 0);
      add_item(KIND_SAMPLE, 0, 5, 5, 5);
      // Restart mid-run, then too few good reads: failure, bias invalid
      add_item(KIND_START, 1, 0, 0, 0);
      add_item(KIND_SAMPLE, 1, 100, 100, 100);
      add_item(KIND_START, 0, 0, 0, 0);
      add_item(KIND_SAMPLE, 0, 1, 1, 1);
      add_item(KIND_SAMPLE, 0, 1, 1, 1);
      add_item(KIND_SAMPLE, 0, 1, 1, 1);
      add_checked(KIND_SAMPLE, 1, 9, 9, 9, RSP_REPORT, 0, 0, 0, 0);
      add_checked(KIND_SAMPLE, 1, 5, 6, 7, RSP_SAMPLE, 5, 6, 7, 0);
      // Longest run, shortened while in progress; negative sums truncate toward zero
      add_csr(65535);
      add_item(KIND_START, 0, 0, 0, 0);
      add_item(KIND_SAMPLE, 1, -5, -6, -8);
      add_item(KIND_SAMPLE, 1, -6, -6, -9);
      add_csr(2);
      add_item(KIND_SAMPLE, 1, -8, -7, -7);
      add_item(KIND_SAMPLE, 1, 0, 32767, -32768);
      // Single-sample runs: zero good reads fails, one good read sets the bias
      add_csr(1);
      add_item(KIND_START, 0, 0, 0, 0);
      add_checked(KIND_SAMPLE, 0, 4, 4, 4, RSP_REPORT, 0, 0, 0, 0);
      add_item(KIND_START, 0, 0, 0, 0);
      add_checked(KIND_SAMPLE, 1, -3, 3, 1, RSP_REPORT, -3, 3, 1, 1);
      add_item(KIND_SAMPLE, 1, -32768, 32767, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].op == ROW_CSR) begin
            drain_idle();
            write_cal_len(dir_rows[i].csr_value);
         end else begin
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) == 0) begin
            drain_idle();
            if ($urandom_range(0, 1)) begin
               pick = $urandom_range(0, 19);
               if (pick == 0) write_cal_len(16'd0);
               else if (pick == 1) write_cal_len(16'd1);
               else if (pick <= 3) write_cal_len(16'($urandom_range(30, 80)));
               else write_cal_len(16'($urandom_range(2, 12)));
            end
         end
         if ($urandom_range(0, 4) != 0) begin
            // Calibration run with random content, then a stream to correct
            case ($urandom_range(0, 2))
               0:       ok_pct = 95;
               1:       ok_pct = 60;
               default: ok_pct = 25;
            endcase
            cx = pick_center();
            cy = pick_center();
            cz = pick_center();
            send_item(make_start(), 1'b0, '0);
            counted++;
            restarted = 1'b0;
            n = 0;
            while (n < drv_len) begin
               if (!restarted && $urandom_range(0, 49) == 0) begin
                  send_item(make_start(), 1'b0, '0);
                  restarted = 1'b1;
                  n = 0;
               end else begin
                  ok = ($urandom_range(1, 100) <= ok_pct);
                  send_item(make_sample(ok, cx, cy, cz), 1'b0, '0);
                  n++;
               end
               counted++;
            end
            m = $urandom_range(4, 30);
            repeat (m) begin
               ok = ($urandom_range(0, 9) != 0);
               send_item(make_sample(ok, cx, cy, cz), 1'b0, '0);
               counted++;
            end
         end else begin
            // Noise: stray starts, bad reads and broken runs
            m = $urandom_range(5, 25);
            repeat (m) begin
               kind = ($urandom_range(0, 5) == 0) ? KIND_START : KIND_SAMPLE;
               ok   = 1'($urandom_range(0, 1));
               send_item({kind, ok, 16'($urandom), 16'($urandom), 16'($urandom)}, 1'b0, '0);
               counted++;
            end
         end
      end

      drain_idle();
      if (errors == 0 && pending_gyro_out.size() == 0) begin
         $display("gyro_bias_calibrate_and_correct test passed");
      end else begin
         $display("gyro_bias_calibrate_and_correct test failed");
      end
      $finish;
   end

endmodule

### sim.f
sv/gbc_pkg.sv
sv/gbc_lane.sv
sv/gbc_merge.sv
sv/gyro_bias_calibrate_and_correct.sv
test/tb_gyro_bias_calibrate_and_correct.sv
